// ----- hdl/weekly_alarm_scheduler_assert.svh -----
// ----------------------------------------------------------------------------
// Weekly alarm scheduler assertion macros
// Shared property forms for the checker of the weekly alarm scheduler.
// ----------------------------------------------------------------------------
`ifndef WEEKLY_ALARM_SCHEDULER_ASSERT_SVH
`define WEEKLY_ALARM_SCHEDULER_ASSERT_SVH

// Same-cycle implication, gated off while reset is high.
`define WAS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("weekly alarm scheduler: same-cycle check failed");

// Next-cycle implication, gated off while the given disable term is high.
`define WAS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("weekly alarm scheduler: next-cycle check failed");

`endif

// ----- hdl/was_pkg.sv -----
// ----------------------------------------------------------------------------
// Weekly alarm scheduler package
// Types, constants and the day-offset functions shared by all modules.
// ----------------------------------------------------------------------------
package was_pkg;

   localparam int ALARM_COUNT = 8;
   localparam int INDEX_WIDTH = 3;
   localparam logic [INDEX_WIDTH-1:0] LAST_INDEX = INDEX_WIDTH'(ALARM_COUNT - 1);

   localparam int DAYS_PER_WEEK      = 7;
   localparam int SECONDS_PER_DAY    = 86400;
   localparam int SECONDS_PER_HOUR   = 3600;
   localparam int SECONDS_PER_MINUTE = 60;

   // Day type codes above the single weekdays
   localparam logic [3:0] DAY_WEEKDAYS = 4'd7;
   localparam logic [3:0] DAY_WEEKEND  = 4'd8;
   localparam logic [3:0] DAY_EVERY    = 4'd9;

   localparam logic [3:0] SUNDAY   = 4'd0;
   localparam logic [3:0] MONDAY   = 4'd1;
   localparam logic [3:0] FRIDAY   = 4'd5;
   localparam logic [3:0] SATURDAY = 4'd6;

   localparam logic [2:0] WEEKDAY_INVALID = 3'd7;

   typedef enum logic [1:0] {
      MODE_SET    = 2'd0,
      MODE_TOGGLE = 2'd1,
      MODE_TICK   = 2'd2
   } mode_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [2:0]  alarm_index;
      logic [3:0]  day_type;
      logic        enable;
      logic [4:0]  alarm_hour;
      logic [5:0]  alarm_minute;
      logic [31:0] now_seconds;
      logic [2:0]  now_weekday;
      logic [4:0]  now_hour;
      logic [5:0]  now_minute;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  alarm_id;
      logic        fired;
      logic [31:0] next_target;
      logic        last;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic                   capture;
      logic                   issue;
      mode_type               kind;
      logic [INDEX_WIDTH-1:0] ptr;
      logic                   last;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic stage_valid;
      logic advance;
   } status_type;

   function automatic logic [2:0] days_until(logic [3:0] today, logic [3:0] goal);
      logic [3:0] diff;
      if (goal < today) begin
         diff = goal + 4'(DAYS_PER_WEEK) - today;
      end else begin
         diff = goal - today;
      end
      return diff[2:0];
   endfunction

   // Whole days from today to the next firing day of an entry
   function automatic logic [2:0] days_ahead(logic [3:0] day, logic [2:0] weekday,
                                             logic past);
      logic [3:0] today;
      logic [3:0] goal;
      logic [2:0] days;
      today = (weekday == WEEKDAY_INVALID) ? SUNDAY : {1'b0, weekday};
      goal  = today;
      days  = 3'd0;
      if (day < 4'(DAYS_PER_WEEK)) begin
         if (day != today) begin
            days = days_until(today, day);
         end else if (past) begin
            days = 3'(DAYS_PER_WEEK);
         end
      end else if (day == DAY_WEEKDAYS) begin
         if (today < MONDAY || today > FRIDAY) begin
            days = days_until(today, MONDAY);
         end else begin
            goal = past ? today + 4'd1 : today;
            if (goal > FRIDAY) begin
               goal = MONDAY;
            end
            days = days_until(today, goal);
         end
      end else if (day == DAY_WEEKEND) begin
         if (today >= MONDAY && today <= FRIDAY) begin
            days = days_until(today, SATURDAY);
         end else begin
            goal = past ? today + 4'd1 : today;
            if (goal > SATURDAY) begin
               goal = SUNDAY;
            end
            if (goal > SUNDAY) begin
               goal = SATURDAY;
            end
            days = days_until(today, goal);
         end
      end else if (day == DAY_EVERY) begin
         days = past ? 3'd1 : 3'd0;
      end
      return days;
   endfunction

endpackage

// ----- hdl/was_ctrl.sv -----
// ----------------------------------------------------------------------------
// Weekly alarm scheduler controller
// Accepts transactions and steps the entry pointer through the datapath.
// ----------------------------------------------------------------------------
module was_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  was_pkg::req_payload_type req_payload,
   input  was_pkg::status_type      status,
   output was_pkg::cmd_type         cmd
);

   was_pkg::state_type                   state_ff, state_in;
   was_pkg::mode_type                    kind_ff, kind_in;
   logic [was_pkg::INDEX_WIDTH-1:0]      ptr_ff, ptr_in;
   logic                                 accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= was_pkg::ST_IDLE;
         kind_ff  <= was_pkg::MODE_TICK;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      ptr_in      = ptr_ff;
      req_stall   = 1'b1;
      accept      = 1'b0;
      cmd.capture = 1'b0;
      cmd.issue   = 1'b0;
      cmd.kind    = kind_ff;
      cmd.ptr     = ptr_ff;
      cmd.last    = (kind_ff != was_pkg::MODE_TICK) || (ptr_ff == was_pkg::LAST_INDEX);
      unique case (state_ff)
         was_pkg::ST_IDLE: begin
            // hold new work until the stage register has drained
            req_stall   = status.stage_valid;
            accept      = req_valid && !status.stage_valid;
            cmd.capture = accept;
            if (accept) begin
               unique case (req_payload.mode) inside
                  was_pkg::MODE_SET, was_pkg::MODE_TOGGLE: begin
                     if (int'(req_payload.alarm_index) < was_pkg::ALARM_COUNT) begin
                        state_in = was_pkg::ST_RUN;
                        kind_in  = was_pkg::mode_type'(req_payload.mode);
                        ptr_in   = was_pkg::INDEX_WIDTH'(req_payload.alarm_index);
                     end
                  end
                  was_pkg::MODE_TICK: begin
                     state_in = was_pkg::ST_RUN;
                     kind_in  = was_pkg::MODE_TICK;
                     ptr_in   = '0;
                  end
                  default: begin
                     // drop unused mode
                  end
               endcase
            end
         end
         was_pkg::ST_RUN: begin
            cmd.issue = !status.stage_valid || status.advance;
            if (cmd.issue) begin
               if (cmd.last) begin
                  state_in = was_pkg::ST_IDLE;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = was_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hdl/was_dpath.sv -----
// ----------------------------------------------------------------------------
// Weekly alarm scheduler datapath
// Entry table, one stage of target arithmetic and the result register.
// ----------------------------------------------------------------------------
module was_dpath (
   input  logic                     clock,
   input  logic                     reset,
   input  was_pkg::req_payload_type req_payload,
   input  was_pkg::cmd_type         cmd,
   output was_pkg::status_type      status,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output was_pkg::rsp_payload_type rsp_payload
);

   // Entry table
   logic [3:0]  ent_day_ff    [was_pkg::ALARM_COUNT];
   logic        ent_en_ff     [was_pkg::ALARM_COUNT];
   logic [4:0]  ent_hour_ff   [was_pkg::ALARM_COUNT];
   logic [5:0]  ent_min_ff    [was_pkg::ALARM_COUNT];
   logic [31:0] ent_target_ff [was_pkg::ALARM_COUNT];

   was_pkg::req_payload_type req_ff;

   // Stage register
   logic                            a_valid_ff;
   was_pkg::mode_type               a_kind_ff;
   logic [was_pkg::INDEX_WIDTH-1:0] a_id_ff;
   logic                            a_last_ff;
   logic [3:0]                      a_day_ff, a_day_in;
   logic                            a_en_ff, a_en_in;
   logic [4:0]                      a_hour_ff, a_hour_in;
   logic [5:0]                      a_min_ff, a_min_in;
   logic [2:0]                      a_days_ff;
   logic [16:0]                     a_neg_ff;
   logic [31:0]                     a_now_ff;
   logic [31:0]                     a_target_ff;
   logic                            a_reached_ff;

   logic        rsp_valid_ff;
   was_pkg::rsp_payload_type rsp_payload_ff;

   logic        advance, load_stage, retire, past;
   logic [31:0] cur_target, pos, new_target;
   logic        recompute;

   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign load_stage = cmd.issue && (advance || !a_valid_ff);
   assign retire     = a_valid_ff && advance;

   assign status.stage_valid = a_valid_ff;
   assign status.advance     = advance;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload        = rsp_payload_ff;

   // Select the entry fields: a set takes them from the transaction, a toggle inverts the enable
   assign cur_target = ent_target_ff[cmd.ptr];
   always_comb begin
      a_day_in  = ent_day_ff[cmd.ptr];
      a_en_in   = ent_en_ff[cmd.ptr];
      a_hour_in = ent_hour_ff[cmd.ptr];
      a_min_in  = ent_min_ff[cmd.ptr];
      case (cmd.kind)
         was_pkg::MODE_SET: begin
            a_day_in  = req_ff.day_type;
            a_en_in   = req_ff.enable;
            a_hour_in = req_ff.alarm_hour;
            a_min_in  = req_ff.alarm_minute;
         end
         was_pkg::MODE_TOGGLE: begin
            a_en_in = !ent_en_ff[cmd.ptr];
         end
         default: begin
         end
      endcase
   end

   assign past = (req_ff.now_hour > a_hour_in) ||
                 ((req_ff.now_hour == a_hour_in) && (req_ff.now_minute >= a_min_in));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance || !a_valid_ff) begin
         a_valid_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (load_stage) begin
         a_kind_ff    <= cmd.kind;
         a_id_ff      <= cmd.ptr;
         a_last_ff    <= cmd.last;
         a_day_ff     <= a_day_in;
         a_en_ff      <= a_en_in;
         a_hour_ff    <= a_hour_in;
         a_min_ff     <= a_min_in;
         a_days_ff    <= was_pkg::days_ahead(a_day_in, req_ff.now_weekday, past);
         a_neg_ff     <= 17'(req_ff.now_hour * 17'(was_pkg::SECONDS_PER_HOUR))
                       + 17'(req_ff.now_minute * 17'(was_pkg::SECONDS_PER_MINUTE));
         a_now_ff     <= req_ff.now_seconds;
         a_target_ff  <= cur_target;
         a_reached_ff <= req_ff.now_seconds >= cur_target;
      end
   end

   // Target arithmetic, modulo 2^32
   assign pos = 32'(a_days_ff) * 32'(was_pkg::SECONDS_PER_DAY)
              + 32'(a_hour_ff) * 32'(was_pkg::SECONDS_PER_HOUR)
              + 32'(a_min_ff) * 32'(was_pkg::SECONDS_PER_MINUTE);
   assign recompute  = (a_kind_ff == was_pkg::MODE_SET) ||
                       ((a_kind_ff == was_pkg::MODE_TICK) && a_reached_ff);
   assign new_target = recompute ? (a_now_ff + pos - 32'(a_neg_ff)) : a_target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < was_pkg::ALARM_COUNT; i++) begin
            ent_day_ff[i]    <= was_pkg::DAY_EVERY;
            ent_en_ff[i]     <= 1'b0;
            ent_hour_ff[i]   <= '0;
            ent_min_ff[i]    <= '0;
            ent_target_ff[i] <= '0;
         end
      end else if (retire) begin
         ent_day_ff[a_id_ff]    <= a_day_ff;
         ent_en_ff[a_id_ff]     <= a_en_ff;
         ent_hour_ff[a_id_ff]   <= a_hour_ff;
         ent_min_ff[a_id_ff]    <= a_min_ff;
         ent_target_ff[a_id_ff] <= new_target;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (retire) begin
         rsp_payload_ff.alarm_id    <= 3'(a_id_ff);
         rsp_payload_ff.fired       <= (a_kind_ff == was_pkg::MODE_TICK) &&
                                       a_reached_ff && a_en_ff;
         rsp_payload_ff.next_target <= new_target;
         rsp_payload_ff.last        <= a_last_ff;
      end
   end

endmodule

// ----- hdl/weekly_alarm_scheduler.sv -----
// ----------------------------------------------------------------------------
// Weekly alarm scheduler
// Table of weekly alarms with set, toggle and tick transactions.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                        Carries
//   req       req_valid/req_stall          one command transaction
//   rsp       rsp_valid/rsp_stall          one result per entry reported
//
// A set or toggle transaction gives one result; the transaction is registered,
// its entry passes the target arithmetic stage and then the result register,
// and the next transaction is taken once the stage register has drained. A
// tick gives ALARM_COUNT results, one per cycle while results are not stalled;
// the entry pointer walks them through the single target arithmetic stage.
// Reset is synchronous and restores every entry (every day, disabled, 00:00,
// target 0). A stalled result holds the stage and the pointer in place.
//
module weekly_alarm_scheduler (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  was_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output was_pkg::rsp_payload_type rsp_payload
);

   // controller drives the pointer, datapath reports stage occupancy
   was_pkg::cmd_type    cmd;
   was_pkg::status_type status;

   was_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .status      (status),
      .cmd         (cmd)
   );

   // the datapath captures the transaction, reads and rewrites the entry
   was_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- hdl/was_checker.sv -----
// ----------------------------------------------------------------------------
// Weekly alarm scheduler checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "weekly_alarm_scheduler_assert.svh"

module was_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input was_pkg::req_payload_type req_payload,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input was_pkg::rsp_payload_type rsp_payload
);

   `WAS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   `WAS_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)

   `WAS_ASSERT_IMPLIES(a_mid_tick_id, clock, reset, rsp_valid && !rsp_payload.last, rsp_payload.alarm_id != 3'(was_pkg::LAST_INDEX))

   `WAS_ASSERT_NEXT(a_tick_busy, clock, reset, req_valid && !req_stall && (req_payload.mode == was_pkg::MODE_TICK), req_stall)

endmodule

bind weekly_alarm_scheduler was_checker u_was_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// ----- verif/weekly_alarm_scheduler_tb.sv -----
// ----------------------------------------------------------------------------
// Weekly alarm scheduler testbench
// Drives set, toggle and tick transactions into the scheduler and checks every
// reported entry against a cycle-free model of the alarm table. A directed
// table comes first, then random sequences that follow a running wall clock
// so that ticks land on and past stored targets, under varied channel idling.
// ----------------------------------------------------------------------------
module weekly_alarm_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import was_pkg::*;

   // Mode code the block ignores
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   // Day type codes past every day: stored, but the target stays on today
   localparam logic [3:0] DAY_UNKNOWN_LO = 4'd10;
   localparam logic [3:0] DAY_UNKNOWN_HI = 4'd15;

   localparam int RESET_CYCLES = 6;
   localparam int QUIET_LIMIT  = 2000;  // cycles with no transaction on any channel
   localparam int HOLD_CYCLES  = 150;   // long receiver hold-off
   localparam int TAIL_CYCLES  = 16;    // drain after the last expected report
   localparam int EPOCH_WEEKDAY = 4;    // second 0 of the wall clock is a Thursday

   logic            clock;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_payload;

   weekly_alarm_scheduler u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Alarm table model and the reports it still owes
   // -------------------------------------------------------------------------
   logic [3:0]  alarm_day [ALARM_COUNT];
   logic        alarm_on  [ALARM_COUNT];
   logic [4:0]  alarm_hr  [ALARM_COUNT];
   logic [5:0]  alarm_min [ALARM_COUNT];
   logic [31:0] alarm_due [ALARM_COUNT];

   rsp_payload_type awaited_reports[$];
   int              errors = 0;

   // Whole days from today forward to a goal weekday, both 0..6
   function automatic int days_forward(int today, int goal);
      return (goal < today) ? goal + DAYS_PER_WEEK - today : goal - today;
   endfunction

   // Next target of entry e, seen from the time stamped on the transaction
   function automatic logic [31:0] due_time(int e, req_payload_type cmd);
      int  today;
      int  goal;
      int  days;
      bit  past;
      today = (cmd.now_weekday == WEEKDAY_INVALID) ? 0 : int'(cmd.now_weekday);
      past  = (cmd.now_hour > alarm_hr[e]) ||
              (cmd.now_hour == alarm_hr[e] && cmd.now_minute >= alarm_min[e]);
      days  = 0;
      if (alarm_day[e] < 4'(DAYS_PER_WEEK)) begin
         if (int'(alarm_day[e]) != today) begin
            days = days_forward(today, int'(alarm_day[e]));
         end else if (past) begin
            days = DAYS_PER_WEEK;
         end
      end else if (alarm_day[e] == DAY_WEEKDAYS) begin
         // From the weekend jump to Monday; on Friday past the time, wrap to Monday
         if (today < 1 || today > 5) begin
            days = days_forward(today, 1);
         end else begin
            goal = past ? today + 1 : today;
            if (goal > 5) goal = 1;
            days = days_forward(today, goal);
         end
      end else if (alarm_day[e] == DAY_WEEKEND) begin
         // Saturday past the time rolls to Sunday, Sunday past the time to Saturday
         if (today >= 1 && today <= 5) begin
            days = days_forward(today, 6);
         end else begin
            goal = past ? today + 1 : today;
            if (goal > 6) goal = 0;
            if (goal > 0) goal = 6;
            days = days_forward(today, goal);
         end
      end else if (alarm_day[e] == DAY_EVERY) begin
         goal = past ? today + 1 : today;
         if (goal > 6) goal = 0;
         days = days_forward(today, goal);
      end
      // Out-of-range hours and minutes go in as they are, all modulo 2^32
      return cmd.now_seconds + 32'(days) * 32'(SECONDS_PER_DAY)
           + 32'(alarm_hr[e]) * 32'(SECONDS_PER_HOUR)
           - 32'(cmd.now_hour) * 32'(SECONDS_PER_HOUR)
           + 32'(alarm_min[e]) * 32'(SECONDS_PER_MINUTE)
           - 32'(cmd.now_minute) * 32'(SECONDS_PER_MINUTE);
   endfunction

   // Advance the table by one accepted transaction and queue the reports it owes.
   // A typed target, where given, replaces the computed one in the report.
   function automatic void apply_command(req_payload_type cmd, bit typed,
                                         logic [31:0] typed_due);
      rsp_payload_type rpt;
      int              idx;
      idx = int'(cmd.alarm_index);
      case (cmd.mode)
         MODE_SET: begin
            alarm_day[idx] = cmd.day_type;
            alarm_on[idx]  = cmd.enable;
            alarm_hr[idx]  = cmd.alarm_hour;
            alarm_min[idx] = cmd.alarm_minute;
            alarm_due[idx] = due_time(idx, cmd);
            rpt = '{alarm_id: cmd.alarm_index, fired: 1'b0,
                    next_target: typed ? typed_due : alarm_due[idx], last: 1'b1};
            awaited_reports.push_back(rpt);
         end
         MODE_TOGGLE: begin
            alarm_on[idx] = ~alarm_on[idx];
            rpt = '{alarm_id: cmd.alarm_index, fired: 1'b0,
                    next_target: typed ? typed_due : alarm_due[idx], last: 1'b1};
            awaited_reports.push_back(rpt);
         end
         MODE_TICK: begin
            // Scan in index order; a reached entry fires only when switched on
            for (int e = 0; e < ALARM_COUNT; e++) begin
               rpt = '{alarm_id: 3'(e), fired: 1'b0, next_target: '0,
                       last: (e == ALARM_COUNT - 1)};
               if (cmd.now_seconds >= alarm_due[e]) begin
                  rpt.fired    = alarm_on[e];
                  alarm_due[e] = due_time(e, cmd);
               end
               rpt.next_target = alarm_due[e];
               awaited_reports.push_back(rpt);
            end
         end
         default: ;  // unused mode: drop, no report
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Result channel: stall pattern, long hold-off, and report checking
   // -------------------------------------------------------------------------
   int snd_idle_pct  = 0;
   int rcv_stall_pct = 0;
   int hold_ask      = 0;   // bumped by the stimulus to request a hold-off
   int hold_taken    = 0;
   int hold_left     = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_ask != hold_taken) begin
         // Start a long hold-off, counted here
         hold_taken <= hold_ask;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_reports.size() == 0) begin
            errors++;
            $display("%0t: unexpected report, expected none, actual %p", $time,
                     rsp_payload);
         end else begin
            want = awaited_reports.pop_front();
            if (rsp_payload.alarm_id !== want.alarm_id) begin
               errors++;
               $display("%0t: alarm_id mismatch, expected %0d, actual %0d", $time,
                        want.alarm_id, rsp_payload.alarm_id);
            end
            if (rsp_payload.fired !== want.fired) begin
               errors++;
               $display("%0t: fired mismatch on entry %0d, expected %0b, actual %0b",
                        $time, want.alarm_id, want.fired, rsp_payload.fired);
            end
            if (rsp_payload.next_target !== want.next_target) begin
               errors++;
               $display("%0t: next_target mismatch on entry %0d, expected %0d, actual %0d",
                        $time, want.alarm_id, want.next_target, rsp_payload.next_target);
            end
            if (rsp_payload.last !== want.last) begin
               errors++;
               $display("%0t: last mismatch on entry %0d, expected %0b, actual %0b",
                        $time, want.alarm_id, want.last, rsp_payload.last);
            end
         end
      end
   end

   // Watchdog: end the run once no transaction has moved for too long
   int quiet = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Command channel
   // -------------------------------------------------------------------------

   // Offer one transaction, idling first at the current rate; hold the payload
   // until it is taken, then advance the model
   task automatic offer(req_payload_type cmd, bit typed = 1'b0,
                        logic [31:0] typed_due = '0);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= cmd;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      apply_command(cmd, typed, typed_due);
   endtask

   function automatic req_payload_type cmd_of(logic [1:0] mode, int idx, logic [3:0] day,
                                              bit en, int hr, int mn, logic [31:0] now,
                                              int wd, int nhr, int nmn);
      req_payload_type c;
      c.mode         = mode;
      c.alarm_index  = 3'(idx);
      c.day_type     = day;
      c.enable       = en;
      c.alarm_hour   = 5'(hr);
      c.alarm_minute = 6'(mn);
      c.now_seconds  = now;
      c.now_weekday  = 3'(wd);
      c.now_hour     = 5'(nhr);
      c.now_minute   = 6'(nmn);
      return c;
   endfunction

   typedef struct {
      req_payload_type cmd;
      bit              typed;
      logic [31:0]     due;
   } directed_row_t;

   directed_row_t directed_rows[$];

   // Running wall clock for well-formed random transactions
   logic [31:0] wall_now;

   // Stamp the wall clock's second, weekday, hour and minute onto a command
   function automatic req_payload_type stamped(req_payload_type c);
      c.now_seconds = wall_now;
      c.now_weekday = 3'((wall_now / SECONDS_PER_DAY + EPOCH_WEEKDAY) % DAYS_PER_WEEK);
      c.now_hour    = 5'((wall_now / SECONDS_PER_HOUR) % 24);
      c.now_minute  = 6'((wall_now / SECONDS_PER_MINUTE) % 60);
      return c;
   endfunction

   // Mostly well-formed sets, toggles and ticks that follow the wall clock;
   // the rest is raw noise over every payload bit
   function automatic req_payload_type random_cmd();
      req_payload_type c;
      logic [95:0]     raw;
      int              pick;
      pick = $urandom_range(99);
      raw  = {$urandom, $urandom, $urandom};
      c    = raw[$bits(req_payload_type)-1:0];
      if (pick < 15) return c;
      if (pick < 55) begin
         wall_now  += $urandom_range(0, 600);
         c.mode         = MODE_SET;
         c.day_type     = 4'($urandom_range(0, 9));
         c.alarm_hour   = 5'($urandom_range(0, 23));
         c.alarm_minute = 6'($urandom_range(0, 59));
      end else if (pick < 73) begin
         c.mode = MODE_TOGGLE;
      end else begin
         // Land on or just past a stored target half the time, else move ahead
         if ($urandom_range(1)) begin
            wall_now = alarm_due[$urandom_range(ALARM_COUNT - 1)] + $urandom_range(0, 120);
         end else begin
            wall_now += $urandom_range(0, 2 * SECONDS_PER_DAY);
         end
         c.mode = MODE_TICK;
      end
      return stamped(c);
   endfunction

   // Random phase; transactions the block ignores do not count
   task automatic run_random(int count, int idle_pct, int stall_pct);
      req_payload_type c;
      int              taken;
      snd_idle_pct  = idle_pct;
      rcv_stall_pct <= stall_pct;
      wall_now      = $urandom;
      taken         = 0;
      while (taken < count) begin
         c = random_cmd();
         offer(c);
         if (c.mode != MODE_UNUSED) taken++;
      end
   endtask

   initial begin
      for (int e = 0; e < ALARM_COUNT; e++) begin
         alarm_day[e] = DAY_EVERY;
         alarm_on[e]  = 1'b0;
         alarm_hr[e]  = '0;
         alarm_min[e] = '0;
         alarm_due[e] = '0;
      end

      // Directed table. Typed targets are the obvious ones: after reset,
      // midnight of day one, and the last minute of day zero.
      directed_rows.push_back('{cmd_of(MODE_TOGGLE, 0, 4'd0, 0, 0, 0, 0, 0, 0, 0), 1, 32'd0});
      directed_rows.push_back('{cmd_of(MODE_TOGGLE, 0, 4'd0, 0, 0, 0, 0, 0, 0, 0), 1, 32'd0});
      directed_rows.push_back('{cmd_of(MODE_UNUSED, 7, DAY_UNKNOWN_HI, 1, 31, 63,
                                       32'hFFFF_FFFF, 7, 31, 63), 0, 0});
      directed_rows.push_back('{cmd_of(MODE_TICK, 0, 4'd0, 0, 0, 0, 0, 0, 0, 0), 0, 0});
      directed_rows.push_back('{cmd_of(MODE_SET, 0, DAY_EVERY, 1, 0, 0, 0, 0, 0, 0),
                                1, 32'd86400});
      directed_rows.push_back('{cmd_of(MODE_SET, 7, SUNDAY, 1, 23, 59, 0, 0, 0, 0),
                                1, 32'd86340});
      // Same weekday with the time passed: a week ahead
      directed_rows.push_back('{cmd_of(MODE_SET, 1, SATURDAY, 1, 6, 30, 32'd1000000,
                                       6, 10, 0), 0, 0});
      // Weekdays: Friday past the time wraps to Monday; Saturday jumps to Monday
      directed_rows.push_back('{cmd_of(MODE_SET, 2, DAY_WEEKDAYS, 1, 7, 0, 32'd2000000,
                                       5, 8, 0), 0, 0});
      directed_rows.push_back('{cmd_of(MODE_SET, 3, DAY_WEEKDAYS, 0, 7, 0, 32'd2100000,
                                       6, 5, 0), 0, 0});
      // Weekend: Sunday past rolls to Saturday, Saturday past to Sunday, midweek
      directed_rows.push_back('{cmd_of(MODE_SET, 4, DAY_WEEKEND, 1, 9, 0, 32'd3000000,
                                       0, 10, 0), 0, 0});
      directed_rows.push_back('{cmd_of(MODE_SET, 5, DAY_WEEKEND, 1, 9, 0, 32'd3100000,
                                       6, 10, 0), 0, 0});
      directed_rows.push_back('{cmd_of(MODE_SET, 5, DAY_WEEKEND, 1, 9, 0, 32'd3200000,
                                       3, 8, 59), 0, 0});
      // Unknown day type with its time already passed: stays on today
      directed_rows.push_back('{cmd_of(MODE_SET, 6, DAY_UNKNOWN_HI, 1, 1, 0, 32'd4000000,
                                       3, 12, 0), 0, 0});
      // Weekday seven counts as Sunday; hour and minute past their ranges
      directed_rows.push_back('{cmd_of(MODE_SET, 6, DAY_UNKNOWN_LO, 1, 31, 63, 32'd5000000,
                                       WEEKDAY_INVALID, 31, 63), 0, 0});
      directed_rows.push_back('{cmd_of(MODE_SET, 3, DAY_EVERY, 1, 0, 0, 32'd6000000,
                                       WEEKDAY_INVALID, 23, 0), 0, 0});
      directed_rows.push_back('{cmd_of(MODE_TOGGLE, 3, 4'd0, 0, 0, 0, 0, 0, 0, 0), 0, 0});
      // Tick at the top of the range: every entry reached, enabled ones fire
      directed_rows.push_back('{cmd_of(MODE_TICK, 0, 4'd0, 0, 0, 0, 32'hFFFF_FFFF,
                                       6, 23, 59), 0, 0});
      directed_rows.push_back('{cmd_of(MODE_TICK, 0, 4'd0, 0, 0, 0, 0, 0, 0, 0), 0, 0});
      // Target that wraps past 2^32
      directed_rows.push_back('{cmd_of(MODE_SET, 1, MONDAY, 1, 0, 0, 32'hFFFF_FF00,
                                       0, 23, 30), 0, 0});
      directed_rows.push_back('{cmd_of(MODE_TICK, 0, 4'd0, 0, 0, 0, 32'h7FFF_FFFF,
                                       2, 12, 30), 0, 0});
      directed_rows.push_back('{cmd_of(MODE_UNUSED, 0, 4'd0, 0, 0, 0, 0, 0, 0, 0), 0, 0});

      // Hold reset, then release it once
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      snd_idle_pct  = 10;
      rcv_stall_pct <= 30;
      foreach (directed_rows[i]) begin
         offer(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].due);
      end

      // Sender idles lightly while the receiver stalls hard, then the reverse
      run_random(100, 21, 88);
      run_random(100, 88, 21);

      // No idling; first a long receiver hold-off so the block backs up
      hold_ask <= hold_ask + 1;
      run_random(40, 0, 0);
      // Pause the sender until every owed report is in
      req_valid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      run_random(60, 0, 0);
      req_valid <= 1'b0;

      // Drain, then let the block settle
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (awaited_reports.size() != 0) begin
         errors++;
         $display("%0t: %0d reports never arrived", $time, awaited_reports.size());
      end
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/was_pkg.sv
hdl/was_ctrl.sv
hdl/was_dpath.sv
hdl/weekly_alarm_scheduler.sv
hdl/was_checker.sv
verif/weekly_alarm_scheduler_tb.sv
